// ===== hw/rtl/nlpd_pkg.sv =====
// Package for the named length-prefixed deframer: field widths, codes and defaults.
// Used by named_length_prefixed_deframer; depends on nothing.
`default_nettype none

package nlpd_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int ENTRY_W    = 4;
    localparam int OFFSET_W   = 5;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int LEN_W      = 32;
    localparam int MASK_W     = 16;
    localparam int LEN_BYTES  = 4;
    localparam int BPOS_W     = 2;

    // packed stream words, padded to whole bytes
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_MASK  = 1'b1;

    // register reset values
    localparam logic [LEN_W-1:0]  LIMIT_RESET = 32'd8192;
    localparam logic [MASK_W-1:0] MASK_RESET  = 16'd0;

    // parameter defaults
    localparam int NAME_BYTES_DEF    = 32;
    localparam int TABLE_ENTRIES_DEF = 16;

    // input commands
    localparam logic [CMD_W-1:0] CMD_STREAM      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TABLE_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART     = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BODY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NAME_LEN     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN_NAME = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BODY_LEN     = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/nlpd_ram.sv =====
// Generic synchronous RAM: one write port, two read ports with registered read data.
// Standalone; reads return the contents before a write at the same edge.
`default_nettype none

module nlpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic      [WIDTH-1:0]                       rdata_a,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic      [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and both registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/named_length_prefixed_deframer.sv =====
// Named length-prefixed deframer: top level with framing control and name matching.
// Depends on nlpd_pkg and nlpd_ram (one instance per name table entry).
// Latency: a body byte, empty-body marker or error appears on m_axis in the cycle after
// the input word that causes it. Throughput: one input word per cycle while m_axis is ready
// or the output register is empty; the name table row for the next name position is read ahead.
// Reset: synchronous on aresetn low; framing state, output valid and the registers
// return to their reset values. The name table is not cleared and is undefined until written.
`default_nettype none

module named_length_prefixed_deframer #(
    parameter int NAME_BYTES    = nlpd_pkg::NAME_BYTES_DEF,
    parameter int TABLE_ENTRIES = nlpd_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // byte_value [7:0], entry_index [11:8], name_offset [16:12], zero pad [23:17]
    input  wire logic [nlpd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // cmd [1:0]
    input  wire logic [nlpd_pkg::CMD_W-1:0]        s_axis_tuser,

    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // handler_index [3:0], body_byte [11:4], error_code [13:12], zero pad [15:14]
    output logic      [nlpd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // kind [1:0]
    output logic      [nlpd_pkg::KIND_W-1:0]       m_axis_tuser,
    // last_in_frame
    output logic                                   m_axis_tlast,

    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [nlpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [nlpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ROW_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int POS_W = $clog2(NAME_BYTES + 1);

    typedef enum logic [2:0] {
        PH_NAME_LEN,
        PH_NAME,
        PH_BODY_LEN,
        PH_BODY,
        PH_STALL
    } phase_t;

    // registers
    phase_t                              phase_reg, phase_next;
    logic [nlpd_pkg::LEN_W-1:0]          len_acc_reg, len_acc_next;
    logic [nlpd_pkg::BPOS_W-1:0]         byte_pos_reg, byte_pos_next;
    logic [nlpd_pkg::LEN_W-1:0]          remain_reg, remain_next;
    logic [POS_W-1:0]                    pos_reg, pos_next;
    logic                                ended_reg, ended_next;
    logic [TABLE_ENTRIES-1:0]            cand_reg, cand_next;
    logic [nlpd_pkg::ENTRY_W-1:0]        match_reg, match_next;
    logic [nlpd_pkg::LEN_W-1:0]          limit_reg;
    logic [nlpd_pkg::MASK_W-1:0]         mask_reg;

    logic                                out_valid_reg;
    logic [nlpd_pkg::KIND_W-1:0]         out_kind_reg;
    logic [nlpd_pkg::ENTRY_W-1:0]        out_handler_reg;
    logic [nlpd_pkg::BYTE_W-1:0]         out_byte_reg;
    logic                                out_last_reg;
    logic [nlpd_pkg::ERR_W-1:0]          out_err_reg;

    // forwarding of a table write that lands on a row being read
    logic                                fwd_valid_reg;
    logic [nlpd_pkg::ENTRY_W-1:0]        fwd_entry_reg;
    logic [ROW_W-1:0]                    fwd_row_reg;
    logic [nlpd_pkg::BYTE_W-1:0]         fwd_byte_reg;
    logic [ROW_W-1:0]                    raddr_a_reg;
    logic [ROW_W-1:0]                    raddr_b_reg;

    // input word fields
    logic                                in_fire;
    logic [nlpd_pkg::CMD_W-1:0]          in_cmd;
    logic [nlpd_pkg::BYTE_W-1:0]         in_byte;
    logic [nlpd_pkg::ENTRY_W-1:0]        in_entry;
    logic [nlpd_pkg::OFFSET_W-1:0]       in_offset;

    // table access
    logic                                tbl_we;
    logic [ROW_W-1:0]                    tbl_row;
    logic [ROW_W-1:0]                    raddr_a;
    logic [ROW_W-1:0]                    raddr_b;
    logic [nlpd_pkg::BYTE_W-1:0]         qa [TABLE_ENTRIES];
    logic [nlpd_pkg::BYTE_W-1:0]         qb [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]            eq_a;
    logic [TABLE_ENTRIES-1:0]            zero_a;
    logic [TABLE_ENTRIES-1:0]            zero_b;

    // name matching
    logic                                name_in_range;
    logic [TABLE_ENTRIES-1:0]            name_cand;
    logic                                name_ended_w;
    logic [POS_W-1:0]                    name_pos_w;
    logic [TABLE_ENTRIES-1:0]            fin_cand;
    logic [TABLE_ENTRIES-1:0]            live;
    logic                                live_any;
    logic [nlpd_pkg::ENTRY_W-1:0]        live_idx;

    // length handling
    logic [nlpd_pkg::LEN_W-1:0]          len_full;
    logic [nlpd_pkg::LEN_W-1:0]          remain_dec;

    // result load
    logic                                out_load;
    logic [nlpd_pkg::KIND_W-1:0]         ld_kind;
    logic [nlpd_pkg::ENTRY_W-1:0]        ld_handler;
    logic [nlpd_pkg::BYTE_W-1:0]         ld_byte;
    logic                                ld_last;
    logic [nlpd_pkg::ERR_W-1:0]          ld_err;

    // handshakes and field unpacking
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser;
    assign in_byte       = s_axis_tdata[7:0];
    assign in_entry      = s_axis_tdata[11:8];
    assign in_offset     = s_axis_tdata[16:12];
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_err_reg, out_byte_reg, out_handler_reg};

    // table write decode, out-of-range writes dropped
    assign tbl_we  = in_fire && (in_cmd == nlpd_pkg::CMD_TABLE_WRITE)
                     && ({1'b0, in_entry} < 5'(TABLE_ENTRIES))
                     && ({2'b00, in_offset} < 7'(NAME_BYTES));
    assign tbl_row = ROW_W'(in_offset);

    // rows for the next name byte and for the terminator check after it
    assign raddr_a = ROW_W'(pos_next);
    assign raddr_b = ROW_W'(pos_next + POS_W'(1));

    // one memory per entry, all read at the same row
    for (genvar e = 0; e < TABLE_ENTRIES; e++) begin : g_entry
        logic                          we_e;
        logic [nlpd_pkg::BYTE_W-1:0]   row_a;
        logic [nlpd_pkg::BYTE_W-1:0]   row_b;
        logic                          fwd_e;

        assign we_e = tbl_we && (in_entry == nlpd_pkg::ENTRY_W'(e));

        nlpd_ram #(
            .WIDTH (nlpd_pkg::BYTE_W),
            .DEPTH (NAME_BYTES)
        ) u_ram (
            .aclk    (aclk),
            .we      (we_e),
            .waddr   (tbl_row),
            .wdata   (in_byte),
            .raddr_a (raddr_a),
            .rdata_a (qa[e]),
            .raddr_b (raddr_b),
            .rdata_b (qb[e])
        );

        // patch in a write from the same edge as the read
        assign fwd_e = fwd_valid_reg && (fwd_entry_reg == nlpd_pkg::ENTRY_W'(e));
        assign row_a = (fwd_e && fwd_row_reg == raddr_a_reg) ? fwd_byte_reg : qa[e];
        assign row_b = (fwd_e && fwd_row_reg == raddr_b_reg) ? fwd_byte_reg : qb[e];

        assign eq_a[e]   = (row_a == in_byte);
        assign zero_a[e] = (row_a == '0);
        assign zero_b[e] = (row_b == '0);
    end

    // name byte step and end-of-name candidate set
    always_comb begin
        name_in_range = (pos_reg < POS_W'(NAME_BYTES));
        name_cand     = (name_in_range && !ended_reg) ? (cand_reg & eq_a) : cand_reg;
        name_ended_w  = ended_reg || (name_in_range && (in_byte == '0));
        name_pos_w    = name_in_range ? (pos_reg + POS_W'(1)) : pos_reg;
        if (phase_reg == PH_NAME_LEN) begin
            fin_cand = zero_a;
        end else if (!name_ended_w && (name_pos_w < POS_W'(NAME_BYTES))) begin
            fin_cand = name_cand & zero_b;
        end else begin
            fin_cand = name_cand;
        end
    end

    // enabled survivors, lowest index wins
    always_comb begin
        live     = fin_cand & mask_reg[TABLE_ENTRIES-1:0];
        live_any = |live;
        live_idx = '0;
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
            if (live[e]) begin
                live_idx = nlpd_pkg::ENTRY_W'(e);
            end
        end
    end

    // length byte assembly, little-endian
    always_comb begin
        len_full = len_acc_reg;
        len_full[8*byte_pos_reg +: 8] = in_byte;
    end

    assign remain_dec = remain_reg - nlpd_pkg::LEN_W'(1);

    // framing control
    always_comb begin
        phase_next    = phase_reg;
        len_acc_next  = len_acc_reg;
        byte_pos_next = byte_pos_reg;
        remain_next   = remain_reg;
        pos_next      = pos_reg;
        ended_next    = ended_reg;
        cand_next     = cand_reg;
        match_next    = match_reg;
        out_load      = 1'b0;
        ld_kind       = nlpd_pkg::KIND_BODY;
        ld_handler    = '0;
        ld_byte       = '0;
        ld_last       = 1'b0;
        ld_err        = nlpd_pkg::ERR_NAME_LEN;

        if (in_fire && (in_cmd == nlpd_pkg::CMD_RESTART)) begin
            phase_next    = PH_NAME_LEN;
            len_acc_next  = '0;
            byte_pos_next = '0;
            remain_next   = '0;
            pos_next      = '0;
            ended_next    = 1'b0;
            cand_next     = '1;
            match_next    = '0;
        end else if (in_fire && (in_cmd == nlpd_pkg::CMD_STREAM)) begin
            unique case (phase_reg)
                PH_NAME_LEN, PH_BODY_LEN: begin
                    if (byte_pos_reg != nlpd_pkg::BPOS_W'(nlpd_pkg::LEN_BYTES - 1)) begin
                        len_acc_next  = len_full;
                        byte_pos_next = byte_pos_reg + nlpd_pkg::BPOS_W'(1);
                    end else begin
                        len_acc_next  = '0;
                        byte_pos_next = '0;
                        if (phase_reg == PH_NAME_LEN) begin
                            if (len_full > limit_reg) begin
                                phase_next = PH_STALL;
                                out_load   = 1'b1;
                                ld_kind    = nlpd_pkg::KIND_ERROR;
                                ld_err     = nlpd_pkg::ERR_NAME_LEN;
                            end else begin
                                remain_next = len_full;
                                pos_next    = '0;
                                ended_next  = 1'b0;
                                cand_next   = '1;
                                if (len_full == '0) begin
                                    // empty name: finish at once against row zero
                                    cand_next = fin_cand;
                                    if (live_any) begin
                                        match_next = live_idx;
                                        phase_next = PH_BODY_LEN;
                                    end else begin
                                        phase_next = PH_STALL;
                                        out_load   = 1'b1;
                                        ld_kind    = nlpd_pkg::KIND_ERROR;
                                        ld_err     = nlpd_pkg::ERR_UNKNOWN_NAME;
                                    end
                                end else begin
                                    phase_next = PH_NAME;
                                end
                            end
                        end else begin
                            if (len_full > limit_reg) begin
                                phase_next = PH_STALL;
                                out_load   = 1'b1;
                                ld_kind    = nlpd_pkg::KIND_ERROR;
                                ld_err     = nlpd_pkg::ERR_BODY_LEN;
                            end else if (len_full == '0) begin
                                // empty body marker, then back to a fresh frame
                                out_load    = 1'b1;
                                ld_kind     = nlpd_pkg::KIND_EMPTY;
                                ld_handler  = match_reg;
                                ld_last     = 1'b1;
                                phase_next  = PH_NAME_LEN;
                                remain_next = '0;
                                pos_next    = '0;
                                ended_next  = 1'b0;
                                cand_next   = '1;
                                match_next  = '0;
                            end else begin
                                remain_next = len_full;
                                phase_next  = PH_BODY;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    remain_next = remain_dec;
                    pos_next    = name_pos_w;
                    ended_next  = name_ended_w;
                    cand_next   = name_cand;
                    if (remain_dec == '0) begin
                        cand_next = fin_cand;
                        if (live_any) begin
                            match_next = live_idx;
                            phase_next = PH_BODY_LEN;
                        end else begin
                            phase_next = PH_STALL;
                            out_load   = 1'b1;
                            ld_kind    = nlpd_pkg::KIND_ERROR;
                            ld_err     = nlpd_pkg::ERR_UNKNOWN_NAME;
                        end
                    end
                end
                PH_BODY: begin
                    remain_next = remain_dec;
                    out_load    = 1'b1;
                    ld_kind     = nlpd_pkg::KIND_BODY;
                    ld_handler  = match_reg;
                    ld_byte     = in_byte;
                    ld_last     = (remain_dec == '0);
                    if (remain_dec == '0) begin
                        phase_next  = PH_NAME_LEN;
                        remain_next = '0;
                        pos_next    = '0;
                        ended_next  = 1'b0;
                        cand_next   = '1;
                        match_next  = '0;
                    end
                end
                default: begin
                    // stalled after an error: stream words are dropped
                end
            endcase
        end
    end

    // state, registers and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_NAME_LEN;
            len_acc_reg   <= '0;
            byte_pos_reg  <= '0;
            remain_reg    <= '0;
            pos_reg       <= '0;
            ended_reg     <= 1'b0;
            cand_reg      <= '1;
            match_reg     <= '0;
            limit_reg     <= nlpd_pkg::LIMIT_RESET;
            mask_reg      <= nlpd_pkg::MASK_RESET;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            len_acc_reg   <= len_acc_next;
            byte_pos_reg  <= byte_pos_next;
            remain_reg    <= remain_next;
            pos_reg       <= pos_next;
            ended_reg     <= ended_next;
            cand_reg      <= cand_next;
            match_reg     <= match_next;
            fwd_valid_reg <= tbl_we;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    nlpd_pkg::CFG_LENGTH_LIMIT: limit_reg <= cfg_data;
                    nlpd_pkg::CFG_ENABLE_MASK:  mask_reg  <= cfg_data[nlpd_pkg::MASK_W-1:0];
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end

        // payload, no reset needed
        if (out_load) begin
            out_kind_reg    <= ld_kind;
            out_handler_reg <= ld_handler;
            out_byte_reg    <= ld_byte;
            out_last_reg    <= ld_last;
            out_err_reg     <= ld_err;
        end
        fwd_entry_reg <= in_entry;
        fwd_row_reg   <= tbl_row;
        fwd_byte_reg  <= in_byte;
        raddr_a_reg   <= raddr_a;
        raddr_b_reg   <= raddr_b;
    end

    // name position sits at zero while a name length is gathered
    a_pos_zero_in_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NAME_LEN) |-> (pos_reg == '0))
        else $error("name position not zero in name length phase");

    // no result once stalled after an error
    a_stall_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STALL) |-> !out_load)
        else $error("result produced while stalled");

    // partial length bytes only in the length phases
    a_bpos_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_pos_reg != '0) |-> ((phase_reg == PH_NAME_LEN) || (phase_reg == PH_BODY_LEN)))
        else $error("length byte position outside a length phase");

    // a frame in name or body always has bytes left
    a_remain_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_NAME) || (phase_reg == PH_BODY)) |-> (remain_reg != '0))
        else $error("no bytes remaining in name or body phase");

    // an error result always leaves the block stalled
    a_error_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (ld_kind == nlpd_pkg::KIND_ERROR)) |=> (phase_reg == PH_STALL))
        else $error("error reported without stalling");

endmodule

`default_nettype wire
